// ----- design/ewvot_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewvot_pkg: shared types and constants for the moving average tracker
// Holds sizes, mode codes, the sequencer state type and the update unit
// interface structs.
// ----------------------------------------------------------------------------
package ewvot_pkg;

  localparam int NumEntries = 64;
  localparam int NumMetrics = 4;
  localparam int EntryW     = 6;
  localparam int MetricW    = 2;
  localparam int SlotW      = EntryW + MetricW;
  localparam int AvgW       = 32;
  localparam int VarW       = 48;
  localparam int CountW     = 7;
  localparam int AlphaW     = 16;
  localparam logic [AlphaW-1:0] AlphaReset = 16'd6554;

  typedef enum logic [2:0] {
    ModeRegister  = 3'd0,
    ModeInitEntry = 3'd1,
    ModeUpdEntry  = 3'd2,
    ModeInitRef   = 3'd3,
    ModeUpdRef    = 3'd4,
    ModeSweep     = 3'd5,
    ModeUnflag    = 3'd6,
    ModeNone      = 3'd7
  } mode_e;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StRead   = 9'b000000010,
    StExec   = 9'b000000100,
    StClear  = 9'b000001000,
    StUpd    = 9'b000010000,
    StSwRd   = 9'b000100000,
    StSwChk  = 9'b001000000,
    StFinal  = 9'b010000000,
    StOut    = 9'b100000000
  } state_e;

  typedef struct packed {
    logic            start;
    logic [AlphaW-1:0] alpha;
    logic signed [AvgW-1:0] avg;
    logic [VarW-1:0] var_in;
    logic signed [AvgW-1:0] sample;
  } upd_req_t;

  typedef struct packed {
    logic            done;
    logic signed [AvgW-1:0] avg;
    logic [VarW-1:0] var_out;
  } upd_rsp_t;

endpackage

// ----- design/ewvot_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewvot_update: moving average and variance update
// One shared 34x34 multiplier, used in six steps under a small counter,
// followed by a saturation step.
// ----------------------------------------------------------------------------
module ewvot_update (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ewvot_pkg::upd_req_t  req_i,
  output ewvot_pkg::upd_rsp_t  rsp_o
);

  logic [2:0]         step_q, step_d;
  logic               busy_q, busy_d;
  logic signed [33:0] delta_q, delta_d;
  logic [32:0]        mag_q, mag_d;
  logic [16:0]        beta_q, beta_d;
  logic [15:0]        alpha_q, alpha_d;
  logic signed [31:0] avg_q, avg_d;
  logic [47:0]        var_q, var_d;
  logic [48:0]        sq_q;
  logic [48:0]        s_q, s_d;
  logic [64:0]        r_q, r_d;
  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  logic               done;

  // shared multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    case (step_q)
      3'd0: begin ma = delta_q; mb = $signed({18'd0, alpha_q}); end
      3'd1: begin ma = $signed({1'b0, mag_q}); mb = $signed({1'b0, mag_q}); end
      3'd2: begin ma = $signed({1'b0, sq_q[48:16]}); mb = $signed({18'd0, alpha_q}); end
      3'd3: begin ma = $signed({18'd0, sq_q[15:0]}); mb = $signed({18'd0, alpha_q}); end
      3'd4: begin ma = $signed({1'b0, s_q[48:16]}); mb = $signed({17'd0, beta_q}); end
      3'd5: begin ma = $signed({18'd0, s_q[15:0]}); mb = $signed({17'd0, beta_q}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign mp = ma * mb;

  always_comb begin
    step_d  = step_q;
    busy_d  = busy_q;
    delta_d = delta_q;
    mag_d   = mag_q;
    beta_d  = beta_q;
    alpha_d = alpha_q;
    avg_d   = avg_q;
    var_d   = var_q;
    s_d     = s_q;
    r_d     = r_q;
    done    = 1'b0;
    if (req_i.start) begin
      busy_d  = 1'b1;
      step_d  = 3'd0;
      delta_d = 34'(req_i.sample) - 34'(req_i.avg);
      mag_d   = 33'(((34'(req_i.sample) - 34'(req_i.avg)) < 0) ?
                (34'(req_i.avg) - 34'(req_i.sample)) :
                (34'(req_i.sample) - 34'(req_i.avg)));
      alpha_d = req_i.alpha;
      beta_d  = 17'h10000 - 17'(req_i.alpha);
      avg_d   = req_i.avg;
      var_d   = req_i.var_in;
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      case (step_q)
        // arithmetic shift floors toward minus infinity
        3'd0: avg_d = 32'(34'(avg_q) + 34'(mp >>> 16));
        // split the square at bit 32 so alpha times it fits the multiplier
        3'd2: s_d = 49'(var_q) + 49'(mp);
        3'd3: s_d = s_q + 49'(mp[67:16]);
        3'd4: r_d = 65'(mp);
        3'd5: r_d = r_q + 65'(mp[67:16]);
        3'd6: begin
          var_d  = (r_q > 65'(48'hFFFF_FFFF_FFFF)) ? 48'hFFFF_FFFF_FFFF : r_q[47:0];
          busy_d = 1'b0;
          done   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // the square, already shifted down by 16, held for the following steps
  always_ff @(posedge clk_i) begin
    if (step_q == 3'd1) sq_q <= mp[64:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    mag_q   <= mag_d;
    beta_q  <= beta_d;
    alpha_q <= alpha_d;
    avg_q   <= avg_d;
    var_q   <= var_d;
    s_q     <= s_d;
    r_q     <= r_d;
  end

  assign rsp_o.done    = done;
  assign rsp_o.avg     = avg_q;
  assign rsp_o.var_out = var_d;

endmodule

// ----- design/ewma_variance_outlier_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewma_variance_outlier_tracker: per entry moving average, variance, flags
// Each input passes through Read and Exec, then Clear, Upd or the sweep states as its
// mode needs, then Final and Out; a sweep reads and checks each entry in turn.
// One transaction at a time; the next input is taken the cycle after the result.
// The update unit runs in seven steps; the slot memory has a registered read port.
// Reset clears flags, registrations, count and reference pairs; alpha returns to 6554.
// ----------------------------------------------------------------------------
module ewma_variance_outlier_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[2:0], entry_index[8:3], metric_index[10:9], sample[42:11], zero fill
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // average[31:0], variance[79:32], entry_known[80], entry_flagged[81],
  // flagged_total[88:82], zero fill
  output logic [95:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int SW = ewvot_pkg::SlotW;

  ewvot_pkg::state_e state_q, state_d;
  logic [15:0] alpha_q;
  logic [2:0]  mode_q;
  logic [5:0]  ent_q;
  logic [1:0]  met_q;
  logic signed [31:0] smp_q;
  logic [ewvot_pkg::NumEntries-1:0] reg_q, flag_q;
  logic [6:0]  cnt_q;
  logic signed [31:0] ref_avg_q [ewvot_pkg::NumMetrics];
  logic [47:0] ref_var_q [ewvot_pkg::NumMetrics];
  logic [6:0]  idx_q;
  logic signed [31:0] mem_avg [2**SW];
  logic [47:0] mem_var [2**SW];
  logic signed [31:0] rd_avg_q;
  logic [47:0] rd_var_q;
  logic        byp_q;
  logic signed [31:0] byp_avg_q;
  logic [47:0] byp_var_q;
  logic [SW-1:0] rd_addr, wr_addr;
  logic        wr_en;
  logic signed [31:0] wr_avg;
  logic [47:0] wr_var;
  logic signed [31:0] out_avg_q;
  logic [47:0] out_var_q;
  logic        out_known_q, out_flag_q;
  logic        upd_ref_q;
  ewvot_pkg::upd_req_t ureq;
  ewvot_pkg::upd_rsp_t ursp;
  logic signed [32:0] diff;
  logic [65:0] dsq;
  logic [47:0] rvar;
  logic        known;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ewvot_pkg::StIdle);
  assign m_axis_tvalid = (state_q == ewvot_pkg::StOut);
  assign m_axis_tdata  = {7'd0, cnt_q, out_flag_q, out_known_q, out_var_q, out_avg_q};
  assign known = reg_q[ent_q];

  always_comb begin
    rd_addr = {ent_q, met_q};
    if (state_q == ewvot_pkg::StSwRd) rd_addr = {idx_q[5:0], met_q};
  end

  // forward data written at the same edge as the read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_avg[wr_addr] <= wr_avg;
      mem_var[wr_addr] <= wr_var;
    end
    rd_avg_q  <= mem_avg[rd_addr];
    rd_var_q  <= mem_var[rd_addr];
    byp_q     <= wr_en && (wr_addr == rd_addr);
    byp_avg_q <= wr_avg;
    byp_var_q <= wr_var;
  end

  assign ureq.start  = (state_q == ewvot_pkg::StExec) &&
                       ((mode_q == ewvot_pkg::ModeUpdEntry && known) ||
                        mode_q == ewvot_pkg::ModeUpdRef);
  assign ureq.alpha  = alpha_q;
  assign ureq.avg    = (mode_q == ewvot_pkg::ModeUpdRef) ? ref_avg_q[met_q] : rd_avg_q;
  assign ureq.var_in = (mode_q == ewvot_pkg::ModeUpdRef) ? ref_var_q[met_q] : rd_var_q;
  assign ureq.sample = smp_q;

  ewvot_update u_update (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ureq),
    .rsp_o (ursp)
  );

  // four standard deviation test without a root
  assign rvar = ref_var_q[met_q];
  assign diff = 33'(rd_avg_q) - 33'(ref_avg_q[met_q]);
  assign dsq  = 66'(diff[31:0]) * 66'(diff[31:0]);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {ent_q, met_q};
    wr_avg  = smp_q;
    wr_var  = '0;
    if (state_q == ewvot_pkg::StClear) begin
      wr_en   = 1'b1;
      wr_addr = {ent_q, idx_q[1:0]};
      wr_avg  = '0;
    end else if (state_q == ewvot_pkg::StExec && mode_q == ewvot_pkg::ModeInitEntry &&
                 known) begin
      wr_en = 1'b1;
    end else if (state_q == ewvot_pkg::StUpd && ursp.done && !upd_ref_q) begin
      wr_en  = 1'b1;
      wr_avg = ursp.avg;
      wr_var = ursp.var_out;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ewvot_pkg::StIdle:  if (s_axis_tvalid) state_d = ewvot_pkg::StRead;
      ewvot_pkg::StRead:  state_d = ewvot_pkg::StExec;
      ewvot_pkg::StExec: begin
        case (mode_q)
          ewvot_pkg::ModeRegister:
            state_d = known ? ewvot_pkg::StRead : ewvot_pkg::StClear;
          ewvot_pkg::ModeUpdEntry:
            state_d = known ? ewvot_pkg::StUpd : ewvot_pkg::StFinal;
          ewvot_pkg::ModeUpdRef: state_d = ewvot_pkg::StUpd;
          ewvot_pkg::ModeSweep:  state_d = ewvot_pkg::StSwRd;
          default: state_d = ewvot_pkg::StRead;
        endcase
        if (mode_q != ewvot_pkg::ModeRegister && mode_q != ewvot_pkg::ModeUpdEntry &&
            mode_q != ewvot_pkg::ModeUpdRef && mode_q != ewvot_pkg::ModeSweep)
          state_d = ewvot_pkg::StFinal;
        if (mode_q == ewvot_pkg::ModeRegister && known) state_d = ewvot_pkg::StFinal;
      end
      ewvot_pkg::StClear: if (idx_q[1:0] == 2'd3) state_d = ewvot_pkg::StFinal;
      ewvot_pkg::StUpd:   if (ursp.done) state_d = ewvot_pkg::StFinal;
      ewvot_pkg::StSwRd:  state_d = ewvot_pkg::StSwChk;
      ewvot_pkg::StSwChk:
        state_d = (idx_q == 7'(ewvot_pkg::NumEntries - 1)) ? ewvot_pkg::StFinal
                                                            : ewvot_pkg::StSwRd;
      ewvot_pkg::StFinal: state_d = ewvot_pkg::StOut;
      ewvot_pkg::StOut:   if (m_axis_tready) state_d = ewvot_pkg::StIdle;
      default: state_d = ewvot_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ewvot_pkg::StIdle;
      alpha_q   <= ewvot_pkg::AlphaReset;
      reg_q     <= '0;
      flag_q    <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      upd_ref_q <= 1'b0;
      for (int i = 0; i < ewvot_pkg::NumMetrics; i++) begin
        ref_avg_q[i] <= '0;
        ref_var_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) alpha_q <= cfg_data_i;
      case (state_q)
        ewvot_pkg::StExec: begin
          idx_q     <= '0;
          upd_ref_q <= (mode_q == ewvot_pkg::ModeUpdRef);
          if (mode_q == ewvot_pkg::ModeInitRef) begin
            ref_avg_q[met_q] <= smp_q;
            ref_var_q[met_q] <= '0;
          end
          if (mode_q == ewvot_pkg::ModeUnflag && known && flag_q[ent_q]) begin
            flag_q[ent_q] <= 1'b0;
            cnt_q <= cnt_q - 7'd1;
          end
        end
        ewvot_pkg::StClear: begin
          idx_q <= idx_q + 7'd1;
          if (idx_q[1:0] == 2'd3) begin
            reg_q[ent_q]  <= 1'b1;
            flag_q[ent_q] <= 1'b0;
          end
        end
        ewvot_pkg::StUpd:
          if (ursp.done && upd_ref_q) begin
            ref_avg_q[met_q] <= ursp.avg;
            ref_var_q[met_q] <= ursp.var_out;
          end
        ewvot_pkg::StSwChk: begin
          idx_q <= idx_q + 7'd1;
          if (reg_q[idx_q[5:0]] && !flag_q[idx_q[5:0]] && !diff[32] && diff != '0 &&
              rvar < 48'h1000_0000_0000 && dsq > 66'({rvar, 20'd0})) begin
            flag_q[idx_q[5:0]] <= 1'b1;
            cnt_q <= cnt_q + 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ewvot_pkg::StIdle && s_axis_tvalid) begin
      mode_q <= s_axis_tdata[2:0];
      ent_q  <= s_axis_tdata[8:3];
      met_q  <= s_axis_tdata[10:9];
      smp_q  <= s_axis_tdata[42:11];
    end
    if (state_q == ewvot_pkg::StFinal) begin
      out_known_q <= known;
      out_flag_q  <= known && flag_q[ent_q];
      if (mode_q == ewvot_pkg::ModeInitRef || mode_q == ewvot_pkg::ModeUpdRef) begin
        out_avg_q <= ref_avg_q[met_q];
        out_var_q <= ref_var_q[met_q];
      end else if (known) begin
        out_avg_q <= byp_q ? byp_avg_q : rd_avg_q;
        out_var_q <= byp_q ? byp_var_q : rd_var_q;
      end else begin
        out_avg_q <= '0;
        out_var_q <= '0;
      end
    end
  end

endmodule
